FILE: rtl/svt_pkg.sv
// Shared types and constants for the sorted value table.
// Used by svt_ctrl, svt_datapath and sorted_value_table_core; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package svt_pkg;

  localparam int unsigned TableDepthDef = 64;
  localparam int unsigned ValueW        = 32;
  localparam int unsigned CountOutW     = 7;
  localparam int unsigned CmdW          = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_INSERT  = 2'd0,
    CMD_DEL_EQ  = 2'd1,
    CMD_DEL_MAX = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_SCAN,
    ST_INS_PLACE,
    ST_DEL_SCAN,
    ST_FINISH
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic ins_scan;
    logic ins_place;
    logic del_scan;
    logic del_done;
    logic load_out;
  } ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic count_zero;
    logic full;
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

FILE: rtl/svt_ram.sv
// Generic single write port, single read port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module svt_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/svt_ctrl.sv
// Command sequencer for the sorted value table.
// Depends on svt_pkg; drives svt_datapath through ctl_t and reads sts_t.
`timescale 1ns / 1ps
`default_nettype none

module svt_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  input  wire logic [1:0]    in_cmd_i,
  output logic               in_ready_o,
  input  wire svt_pkg::sts_t sts_i,
  output svt_pkg::ctl_t      ctl_o
);

  svt_pkg::state_e state_q, state_d;
  svt_pkg::cmd_e   cmd;
  logic            accept;

  assign cmd    = svt_pkg::cmd_e'(in_cmd_i);
  assign accept = in_valid_i && (state_q == svt_pkg::ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= svt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      svt_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (cmd)
            svt_pkg::CMD_INSERT: begin
              if (sts_i.full)            state_d = svt_pkg::ST_FINISH;
              else if (sts_i.count_zero) state_d = svt_pkg::ST_INS_PLACE;
              else                       state_d = svt_pkg::ST_INS_SCAN;
            end
            svt_pkg::CMD_DEL_EQ, svt_pkg::CMD_DEL_MAX: begin
              if (sts_i.count_zero) state_d = svt_pkg::ST_FINISH;
              else                  state_d = svt_pkg::ST_DEL_SCAN;
            end
            svt_pkg::CMD_CLEAR: state_d = svt_pkg::ST_FINISH;
            default: state_d = svt_pkg::ST_FINISH;
          endcase
        end
      end
      svt_pkg::ST_INS_SCAN: begin
        if (sts_i.scan_done) state_d = svt_pkg::ST_INS_PLACE;
      end
      svt_pkg::ST_INS_PLACE: state_d = svt_pkg::ST_FINISH;
      svt_pkg::ST_DEL_SCAN: begin
        if (sts_i.scan_done) state_d = svt_pkg::ST_FINISH;
      end
      svt_pkg::ST_FINISH: begin
        if (sts_i.out_free) state_d = svt_pkg::ST_IDLE;
      end
      default: state_d = svt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o      = (state_q == svt_pkg::ST_IDLE);
    ctl_o           = '0;
    ctl_o.accept    = accept;
    ctl_o.ins_scan  = (state_q == svt_pkg::ST_INS_SCAN);
    ctl_o.ins_place = (state_q == svt_pkg::ST_INS_PLACE);
    ctl_o.del_scan  = (state_q == svt_pkg::ST_DEL_SCAN);
    ctl_o.del_done  = (state_q == svt_pkg::ST_DEL_SCAN) && sts_i.scan_done;
    ctl_o.load_out  = (state_q == svt_pkg::ST_FINISH) && sts_i.out_free;
  end

endmodule

`default_nettype wire

FILE: rtl/svt_datapath.sv
// Datapath of the sorted value table: entry RAM, scan pointers, bounds and result register.
// Depends on svt_pkg and svt_ram; steered by svt_ctrl through ctl_t.
`timescale 1ns / 1ps
`default_nettype none

module svt_datapath #(
  parameter int unsigned TableDepth = svt_pkg::TableDepthDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire svt_pkg::ctl_t                   ctl_i,
  output svt_pkg::sts_t                        sts_o,
  input  wire logic [1:0]                      in_cmd_i,
  input  wire logic signed [svt_pkg::ValueW-1:0] in_value_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_ready_i,
  output logic [svt_pkg::CountOutW-1:0]        out_entry_count_o,
  output logic [svt_pkg::CountOutW-1:0]        out_removed_count_o,
  output logic                                 out_insert_dropped_o,
  output logic                                 out_is_empty_o,
  output logic signed [svt_pkg::ValueW-1:0]    out_smallest_o,
  output logic signed [svt_pkg::ValueW-1:0]    out_largest_o
);

  localparam int unsigned AW = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int unsigned CW = $clog2(TableDepth + 1);
  localparam int unsigned VW = svt_pkg::ValueW;

  svt_pkg::cmd_e cmd;

  logic [CW-1:0]        count_q, wr_q, removed_q;
  logic                 issue_q, pend_q, out_valid_q, dropped_q;
  logic [AW-1:0]        ridx_q, pidx_q, place_q;
  logic signed [VW-1:0] val_q, lo_q, hi_q;

  logic [CW-1:0]        res_count_q, res_removed_q;
  logic                 res_dropped_q, res_empty_q;
  logic signed [VW-1:0] res_lo_q, res_hi_q;

  logic signed [VW-1:0] rdata;
  logic                 scanning, last_issue, ins_hit, ins_found, del_keep;
  logic                 we, re;
  logic [AW-1:0]        waddr;
  logic [VW-1:0]        wdata;

  assign cmd        = svt_pkg::cmd_e'(in_cmd_i);
  assign scanning   = ctl_i.ins_scan || ctl_i.del_scan;
  assign last_issue = ctl_i.ins_scan ? (ridx_q == '0) : (ridx_q == AW'(count_q - 1'b1));
  assign ins_hit    = ctl_i.ins_scan && pend_q && (rdata >= val_q);
  assign ins_found  = ctl_i.ins_scan && pend_q && (rdata < val_q);
  assign del_keep   = ctl_i.del_scan && pend_q && (rdata != val_q);

  assign re = scanning && issue_q && !ins_found;

  always_comb begin
    we    = 1'b0;
    waddr = pidx_q;
    wdata = rdata;
    priority if (ctl_i.ins_place) begin
      we    = 1'b1;
      waddr = place_q;
      wdata = val_q;
    end else if (ins_hit) begin
      we    = 1'b1;
      waddr = AW'(pidx_q + 1'b1);
    end else if (del_keep) begin
      we    = 1'b1;
      waddr = AW'(wr_q);
    end
  end

  svt_ram #(
    .Width(VW),
    .Depth(TableDepth)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (ridx_q),
    .rdata_o (rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      issue_q     <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (ctl_i.accept) begin
        issue_q <= 1'b1;
        pend_q  <= 1'b0;
        if (cmd == svt_pkg::CMD_CLEAR) count_q <= '0;
      end else if (scanning) begin
        if (ins_found) begin
          issue_q <= 1'b0;
          pend_q  <= 1'b0;
        end else begin
          pend_q <= issue_q;
          if (issue_q && last_issue) issue_q <= 1'b0;
        end
      end
      if (ctl_i.ins_place) count_q <= count_q + 1'b1;
      if (ctl_i.del_done)  count_q <= wr_q;
      if (ctl_i.load_out)  out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.accept) begin
      ridx_q    <= (cmd == svt_pkg::CMD_INSERT) ? AW'(count_q - 1'b1) : '0;
      wr_q      <= '0;
      place_q   <= '0;
      val_q     <= (cmd == svt_pkg::CMD_DEL_MAX) ? hi_q : in_value_i;
      removed_q <= (cmd == svt_pkg::CMD_CLEAR) ? count_q : '0;
      dropped_q <= (cmd == svt_pkg::CMD_INSERT) && (count_q >= CW'(TableDepth));
    end else if (scanning) begin
      if (ins_found) begin
        place_q <= AW'(pidx_q + 1'b1);
      end else if (issue_q) begin
        pidx_q <= ridx_q;
        if (!last_issue) ridx_q <= ctl_i.ins_scan ? ridx_q - 1'b1 : ridx_q + 1'b1;
      end
      if (del_keep) begin
        wr_q <= wr_q + 1'b1;
        hi_q <= rdata;
        if (wr_q == '0) lo_q <= rdata;
      end
    end
    if (ctl_i.ins_place) begin
      if (count_q == '0 || val_q < lo_q) lo_q <= val_q;
      if (count_q == '0 || val_q > hi_q) hi_q <= val_q;
    end
    if (ctl_i.del_done) removed_q <= count_q - wr_q;
    if (ctl_i.load_out) begin
      res_count_q   <= count_q;
      res_removed_q <= removed_q;
      res_dropped_q <= dropped_q;
      res_empty_q   <= (count_q == '0);
      res_lo_q      <= (count_q == '0) ? '0 : lo_q;
      res_hi_q      <= (count_q == '0) ? '0 : hi_q;
    end
  end

  assign sts_o.count_zero = (count_q == '0);
  assign sts_o.full       = (count_q >= CW'(TableDepth));
  assign sts_o.scan_done  = !issue_q && !pend_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o          = out_valid_q;
  assign out_entry_count_o    = svt_pkg::CountOutW'(res_count_q);
  assign out_removed_count_o  = svt_pkg::CountOutW'(res_removed_q);
  assign out_insert_dropped_o = res_dropped_q;
  assign out_is_empty_o       = res_empty_q;
  assign out_smallest_o       = res_lo_q;
  assign out_largest_o        = res_hi_q;

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(TableDepth))
    else $error("entry count above table depth");

  a_compact_ptr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.del_scan |-> wr_q <= count_q)
    else $error("compaction write pointer past entry count");

  a_shift_addr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ins_hit |-> ({1'b0, pidx_q} < (AW + 1)'(count_q)))
    else $error("insert shift beyond stored entries");

  a_bounds_order : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != '0 && !scanning && !ctl_i.accept) |-> (lo_q <= hi_q))
    else $error("smallest above largest");

endmodule

`default_nettype wire

FILE: rtl/sorted_value_table_core.sv
// Sorted value table: a bounded table of signed values kept in ascending order.
// Requests on the in channel carry a command (insert, delete equal, delete largest,
// clear) and a value; each request yields one response on the out channel with
// the entry count, removed count, dropped-insert flag, empty flag and bounds.
// Both channels are valid/ready; a request is taken only while the sequencer idles.
// Clear, a full-table insert and a delete on an empty table go straight to the finishing
// step; an insert into an empty table places the value without a scan; other inserts
// scan down from the largest entry until an entry smaller than the value ends the scan
// or the bottom is reached, and delete equal and delete largest scan every stored entry.
// The entry RAM has a single read port and is scanned one entry a cycle.
// The next request can be taken in the cycle after a response is loaded.
// The response sits in an output register: the next request is taken while it
// waits, and a finished request holds in its last step until the receiver takes
// the previous response. Reset empties the table at once; entry contents need no
// clearing as only entries below the count are ever read.
// Depends on svt_pkg, svt_ctrl, svt_datapath and svt_ram.
`timescale 1ns / 1ps
`default_nettype none

module sorted_value_table_core #(
  parameter int unsigned TableDepth = svt_pkg::TableDepthDef
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               in_valid_i,
  output logic                                    in_ready_o,
  input  wire logic [1:0]                         in_cmd_i,
  input  wire logic signed [svt_pkg::ValueW-1:0]  in_value_i,
  output logic                                    out_valid_o,
  input  wire logic                               out_ready_i,
  output logic [svt_pkg::CountOutW-1:0]           out_entry_count_o,
  output logic [svt_pkg::CountOutW-1:0]           out_removed_count_o,
  output logic                                    out_insert_dropped_o,
  output logic                                    out_is_empty_o,
  output logic signed [svt_pkg::ValueW-1:0]       out_smallest_o,
  output logic signed [svt_pkg::ValueW-1:0]       out_largest_o
);

  svt_pkg::ctl_t ctl;
  svt_pkg::sts_t sts;

  svt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_cmd_i   (in_cmd_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  svt_datapath #(
    .TableDepth(TableDepth)
  ) u_datapath (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .ctl_i                (ctl),
    .sts_o                (sts),
    .in_cmd_i             (in_cmd_i),
    .in_value_i           (in_value_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .out_entry_count_o    (out_entry_count_o),
    .out_removed_count_o  (out_removed_count_o),
    .out_insert_dropped_o (out_insert_dropped_o),
    .out_is_empty_o       (out_is_empty_o),
    .out_smallest_o       (out_smallest_o),
    .out_largest_o        (out_largest_o)
  );

endmodule

`default_nettype wire

FILE: tb/sorted_value_table_core_tb.sv
// Testbench for sorted_value_table_core: directed and random command streams, with a
// queue-based model of the sorted table predicting each response.
// Depends on svt_pkg and the sorted_value_table_core RTL.
`timescale 1ns / 1ps

module sorted_value_table_core_tb;
  import svt_pkg::*;

  localparam int unsigned TableDepth = TableDepthDef;
  localparam int unsigned IdleLimit  = 2000;
  localparam logic signed [ValueW-1:0] MaxValue = 32'sh7fff_ffff;
  localparam logic signed [ValueW-1:0] MinValue = 32'sh8000_0000;

  typedef struct packed {
    logic [CountOutW-1:0]     entry_count;
    logic [CountOutW-1:0]     removed_count;
    logic                     insert_dropped;
    logic                     is_empty;
    logic signed [ValueW-1:0] smallest;
    logic signed [ValueW-1:0] largest;
  } table_status_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic [1:0]               in_cmd_i;
  logic signed [ValueW-1:0] in_value_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [CountOutW-1:0]     out_entry_count_o;
  logic [CountOutW-1:0]     out_removed_count_o;
  logic                     out_insert_dropped_o;
  logic                     out_is_empty_o;
  logic signed [ValueW-1:0] out_smallest_o;
  logic signed [ValueW-1:0] out_largest_o;

  logic signed [ValueW-1:0] model_entries[$];
  table_status_t            expected_status_q[$];
  int                       error_count;
  int                       gap_left;
  int                       burst_left;
  bit                       request_line_up;
  int                       idle_cycles;
  int                       stall_left;
  int                       stall_mode;
  int                       pattern_timer;

  sorted_value_table_core u_dut (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .in_valid_i           (in_valid_i),
    .in_ready_o           (in_ready_o),
    .in_cmd_i             (in_cmd_i),
    .in_value_i           (in_value_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .out_entry_count_o    (out_entry_count_o),
    .out_removed_count_o  (out_removed_count_o),
    .out_insert_dropped_o (out_insert_dropped_o),
    .out_is_empty_o       (out_is_empty_o),
    .out_smallest_o       (out_smallest_o),
    .out_largest_o        (out_largest_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // applies one command to the model table and returns the status it should report
  function automatic table_status_t predict_table_status(cmd_e cmd, logic signed [ValueW-1:0] value);
    table_status_t            status;
    logic signed [ValueW-1:0] kept[$];
    logic signed [ValueW-1:0] key;
    int                       pos;
    status = '0;
    case (cmd)
      CMD_INSERT: begin
        if (model_entries.size() >= TableDepth) begin
          status.insert_dropped = 1'b1;
        end else begin
          pos = 0;
          while (pos < model_entries.size() && model_entries[pos] < value) pos++;
          model_entries.insert(pos, value);
        end
      end
      CMD_DEL_EQ, CMD_DEL_MAX: begin
        if (cmd == CMD_DEL_EQ || model_entries.size() > 0) begin
          key = (cmd == CMD_DEL_EQ) ? value : model_entries[$];
          foreach (model_entries[i]) begin
            if (model_entries[i] != key) kept.push_back(model_entries[i]);
          end
          status.removed_count = CountOutW'(model_entries.size() - kept.size());
          model_entries = kept;
        end
      end
      default: begin
        status.removed_count = CountOutW'(model_entries.size());
        model_entries.delete();
      end
    endcase
    status.entry_count = CountOutW'(model_entries.size());
    status.is_empty    = (model_entries.size() == 0);
    if (model_entries.size() > 0) begin
      status.smallest = model_entries[0];
      status.largest  = model_entries[$];
    end
    return status;
  endfunction

  function automatic logic signed [ValueW-1:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1, 2: return $signed($urandom);
      3, 4:    return $signed($urandom_range(0, 20)) - 10;
      5: begin
        case ($urandom_range(0, 3))
          0:       return MaxValue;
          1:       return MinValue;
          2:       return 0;
          default: return -1;
        endcase
      end
      default: begin
        if (model_entries.size() == 0) return $signed($urandom);
        return model_entries[$urandom_range(0, model_entries.size() - 1)];
      end
    endcase
  endfunction

  function automatic logic signed [ValueW-1:0] pick_stored_value();
    if (model_entries.size() == 0 || $urandom_range(0, 9) < 3) return pick_value();
    return model_entries[$urandom_range(0, model_entries.size() - 1)];
  endfunction

  // one request; sender sends in bursts with random idle gaps between them
  task automatic send_request(cmd_e cmd, logic signed [ValueW-1:0] value);
    while (gap_left > 0) begin
      @(posedge clk_i);
      gap_left--;
    end
    in_valid_i      <= 1'b1;
    in_cmd_i        <= cmd;
    in_value_i      <= value;
    request_line_up = 1'b1;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    expected_status_q.push_back(predict_table_status(cmd, value));
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
    end
    if (gap_left > 0) begin
      in_valid_i      <= 1'b0;
      request_line_up = 1'b0;
    end
  endtask

  task automatic send_random_command(int insert_pct, int del_eq_pct, int del_max_pct,
                                     bit narrow_values);
    int                       roll;
    logic signed [ValueW-1:0] value;
    roll  = $urandom_range(0, 99);
    value = narrow_values ? $signed($urandom_range(0, 4)) - 2 : pick_value();
    if (roll < insert_pct) begin
      send_request(CMD_INSERT, value);
    end else if (roll < insert_pct + del_eq_pct) begin
      send_request(CMD_DEL_EQ, narrow_values ? value : pick_stored_value());
    end else if (roll < insert_pct + del_eq_pct + del_max_pct) begin
      send_request(CMD_DEL_MAX, $signed($urandom));
    end else begin
      send_request(CMD_CLEAR, $signed($urandom));
    end
  endtask

  task automatic test_empty_table_cases();
    send_request(CMD_DEL_MAX, 5);
    send_request(CMD_DEL_EQ, 0);
    send_request(CMD_CLEAR, MaxValue);
  endtask

  task automatic test_value_extremes();
    send_request(CMD_INSERT, MaxValue);
    send_request(CMD_INSERT, MinValue);
    send_request(CMD_INSERT, 0);
    send_request(CMD_INSERT, -1);
    send_request(CMD_INSERT, 1);
    send_request(CMD_INSERT, -1);
    send_request(CMD_DEL_EQ, -1);
    send_request(CMD_DEL_EQ, 7);
    send_request(CMD_DEL_MAX, MinValue);
    send_request(CMD_INSERT, MinValue);
    send_request(CMD_INSERT, 32'sh5555_aaaa);
    send_request(CMD_INSERT, 32'sh5555_aaaa);
    send_request(CMD_DEL_MAX, 0);
    send_request(CMD_DEL_EQ, MinValue);
    send_request(CMD_INSERT, 32'shaaaa_5555);
    send_request(CMD_CLEAR, -1);
  endtask

  task automatic test_random_mix(int count);
    repeat (count) send_random_command(50, 22, 22, 1'b0);
  endtask

  task automatic test_full_table(int rounds);
    repeat (rounds) begin
      send_request(CMD_CLEAR, $signed($urandom));
      while (model_entries.size() < TableDepth) send_request(CMD_INSERT, pick_value());
      repeat ($urandom_range(3, 8)) send_request(CMD_INSERT, pick_value());
      send_request(CMD_DEL_EQ, pick_stored_value());
      while (model_entries.size() < TableDepth) send_request(CMD_INSERT, pick_value());
      send_request(CMD_INSERT, pick_value());
      repeat ($urandom_range(2, 6)) send_request(CMD_DEL_MAX, $signed($urandom));
    end
  endtask

  task automatic test_duplicate_runs(int count);
    repeat (count) send_random_command(55, 20, 20, 1'b1);
  endtask

  // receiver: alternates between no stalls, short frequent stalls and long rare ones
  always @(posedge clk_i) begin
    if (pattern_timer == 0) begin
      stall_mode    = $urandom_range(0, 2);
      pattern_timer = $urandom_range(50, 400);
    end else begin
      pattern_timer--;
    end
    if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left--;
    end else if (stall_mode == 1 && $urandom_range(0, 2) == 0) begin
      out_ready_i <= 1'b0;
      stall_left = $urandom_range(0, 2);
    end else if (stall_mode == 2 && $urandom_range(0, 9) == 0) begin
      out_ready_i <= 1'b0;
      stall_left = $urandom_range(4, 39);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  task automatic check_field(string name, logic signed [ValueW-1:0] want,
                             logic signed [ValueW-1:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin : response_check
    table_status_t want;
    if (rst_ni === 1'b1 && out_valid_o === 1'b1 && out_ready_i) begin
      if (expected_status_q.size() == 0) begin
        $display("%0t ns: response with no request outstanding, expected none, actual count %0d",
                 $time, out_entry_count_o);
        error_count++;
      end else begin
        want = expected_status_q.pop_front();
        check_field("entry_count", want.entry_count, out_entry_count_o);
        check_field("removed_count", want.removed_count, out_removed_count_o);
        check_field("insert_dropped", want.insert_dropped, out_insert_dropped_o);
        check_field("is_empty", want.is_empty, out_is_empty_o);
        check_field("smallest", want.smallest, out_smallest_o);
        check_field("largest", want.largest, out_largest_o);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("%0t ns: watchdog expired, %0d responses outstanding",
                 $time, expected_status_q.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    in_cmd_i        = CMD_INSERT;
    in_value_i      = '0;
    out_ready_i     = 1'b0;
    error_count     = 0;
    gap_left        = 0;
    burst_left      = 0;
    request_line_up = 1'b0;
    idle_cycles     = 0;
    stall_left      = 0;
    stall_mode      = 0;
    pattern_timer   = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_empty_table_cases();
    test_value_extremes();
    test_random_mix(900);
    test_full_table(4);
    test_duplicate_runs(350);

    if (request_line_up) in_valid_i <= 1'b0;
    while (expected_status_q.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/svt_pkg.sv
rtl/svt_ram.sv
rtl/svt_ctrl.sv
rtl/svt_datapath.sv
rtl/sorted_value_table_core.sv
tb/sorted_value_table_core_tb.sv
